>>> sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants for the Cartesian-to-polar byte converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

   localparam int C2P_COORD_WIDTH   = 16;
   localparam int C2P_CORDIC_STAGES = 14;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RADIUS_SCALE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_COLUMN     = 8'd1;

   localparam logic [15:0] RADIUS_SCALE_RESET = 16'd8192;
   localparam logic [7:0]  X_COLUMN_RESET     = 8'd240;

   localparam int GUARD_BITS   = 8;
   localparam int HEADROOM     = 3;
   localparam int ANGLE_WIDTH  = 24;
   localparam int MAX_STAGES   = 24;
   localparam int GAIN_WIDTH   = 30;
   localparam int GAIN_SHIFT   = 15;

   localparam logic [ANGLE_WIDTH-1:0] HALF_TURN   = 24'h800000;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_ROUND = 24'h008000;
   localparam logic [GAIN_WIDTH-1:0]  INV_GAIN    = 30'd652032874;

   localparam logic [ANGLE_WIDTH-1:0] ATAN_TURNS [MAX_STAGES] = '{
      24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
      24'd166669,  24'd83416,   24'd41718,  24'd20860,
      24'd10430,   24'd5215,    24'd2608,   24'd1304,
      24'd652,     24'd326,     24'd163,    24'd81,
      24'd41,      24'd20,      24'd10,     24'd5,
      24'd3,       24'd1,       24'd1,      24'd0
   };

endpackage

`default_nettype wire

>>> sv/c2p_prep.sv
// ----------------------------------------------------------------------------
// c2p_prep
// Input stage: scale coordinates, fold the left half plane, flag the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_prep #(
   parameter int COORD_WIDTH = 16,
   parameter int DATA_WIDTH  = 27
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic signed [COORD_WIDTH-1:0]          x_coord,
   input  wire logic signed [COORD_WIDTH-1:0]          y_coord,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic signed [DATA_WIDTH-1:0]                x_out,
   output logic signed [DATA_WIDTH-1:0]                y_out,
   output logic [c2p_pkg::ANGLE_WIDTH-1:0]             z_out,
   output logic                                        nz_out
);
   import c2p_pkg::*;

   logic                         valid_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   logic [ANGLE_WIDTH-1:0]       z_ff, z_in;
   logic                         nz_ff, nz_in;
   logic signed [DATA_WIDTH-1:0] xs;
   logic signed [DATA_WIDTH-1:0] ys;

   assign xs = DATA_WIDTH'(x_coord) <<< GUARD_BITS;
   assign ys = DATA_WIDTH'(y_coord) <<< GUARD_BITS;

   always_comb begin
      nz_in = (x_coord != '0) || (y_coord != '0);
      if (x_coord[COORD_WIDTH-1]) begin
         x_in = -xs;
         y_in = -ys;
         z_in = HALF_TURN;
      end else begin
         x_in = xs;
         y_in = ys;
         z_in = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         nz_ff <= nz_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign nz_out    = nz_ff;

endmodule

`default_nettype wire

>>> sv/c2p_cordic_stage.sv
// ----------------------------------------------------------------------------
// c2p_cordic_stage
// One registered CORDIC vectoring rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_cordic_stage #(
   parameter int DATA_WIDTH = 27,
   parameter int STAGE      = 0
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic signed [DATA_WIDTH-1:0]           x_in_d,
   input  wire logic signed [DATA_WIDTH-1:0]           y_in_d,
   input  wire logic [c2p_pkg::ANGLE_WIDTH-1:0]        z_in_d,
   input  wire logic                                   nz_in_d,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic signed [DATA_WIDTH-1:0]                x_out,
   output logic signed [DATA_WIDTH-1:0]                y_out,
   output logic [c2p_pkg::ANGLE_WIDTH-1:0]             z_out,
   output logic                                        nz_out
);
   import c2p_pkg::*;

   localparam logic [ANGLE_WIDTH-1:0] ATAN = ATAN_TURNS[STAGE];

   logic                         valid_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   logic [ANGLE_WIDTH-1:0]       z_ff, z_in;
   logic                         nz_ff;
   logic signed [DATA_WIDTH-1:0] dx;
   logic signed [DATA_WIDTH-1:0] dy;

   assign dx = y_in_d >>> STAGE;
   assign dy = x_in_d >>> STAGE;

   always_comb begin
      if (!y_in_d[DATA_WIDTH-1]) begin
         x_in = x_in_d + dx;
         y_in = y_in_d - dy;
         z_in = z_in_d + ATAN;
      end else begin
         x_in = x_in_d - dx;
         y_in = y_in_d + dy;
         z_in = z_in_d - ATAN;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         nz_ff <= nz_in_d;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign nz_out    = nz_ff;

endmodule

`default_nettype wire

>>> sv/c2p_radius.sv
// ----------------------------------------------------------------------------
// c2p_radius
// Back end: gain correction, radius scaling, rounding, saturation, angle byte.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_radius #(
   parameter int DATA_WIDTH = 27
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic signed [DATA_WIDTH-1:0]           x_in_d,
   input  wire logic [c2p_pkg::ANGLE_WIDTH-1:0]        z_in_d,
   input  wire logic                                   nz_in_d,
   input  wire logic [15:0]                            radius_scale,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic [7:0]                                  angle_code,
   output logic [7:0]                                  radius_code,
   output logic                                        radius_saturated
);
   import c2p_pkg::*;

   localparam int MW  = DATA_WIDTH - 1;
   localparam int HIW = MW - GAIN_SHIFT;
   localparam int PHW = HIW + GAIN_WIDTH;
   localparam int PLW = GAIN_SHIFT + GAIN_WIDTH;
   localparam int SUW = PHW + 1;
   localparam int RW  = SUW - GAIN_SHIFT;
   localparam int SW  = RW + 16;
   localparam int VW  = SW + 1 - 24;

   logic [MW-1:0]          m;
   logic [ANGLE_WIDTH-1:0] z_round;
   logic [PLW-1:0]         lo_full;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic                   r1, r2, r3, r4;

   logic [PHW-1:0]         hi1_ff, hi1_in;
   logic [GAIN_WIDTH-1:0]  lo1_ff, lo1_in;
   logic [7:0]             ang1_ff, ang1_in;
   logic [SUW-1:0]         sum2;
   logic [RW-1:0]          r2_ff, r2_in;
   logic [7:0]             ang2_ff;
   logic [SW-1:0]          s3_ff, s3_in;
   logic [7:0]             ang3_ff;
   logic [SW:0]            s_round;
   logic [VW-1:0]          v;
   logic [7:0]             code4_ff, code4_in;
   logic                   sat4_ff, sat4_in;
   logic [7:0]             ang4_ff;

   // stage 1: gain partial products
   always_comb begin
      m       = (nz_in_d && !x_in_d[DATA_WIDTH-1]) ? x_in_d[MW-1:0] : '0;
      z_round = z_in_d + ANGLE_ROUND;
      ang1_in = nz_in_d ? z_round[ANGLE_WIDTH-1:ANGLE_WIDTH-8] : 8'd0;
      hi1_in  = PHW'(m[MW-1:GAIN_SHIFT]) * PHW'(INV_GAIN);
      lo_full = PLW'(m[GAIN_SHIFT-1:0]) * PLW'(INV_GAIN);
      lo1_in  = lo_full[PLW-1:GAIN_SHIFT];
   end

   // stage 2: combine and drop fraction
   always_comb begin
      sum2  = SUW'(hi1_ff) + SUW'(lo1_ff);
      r2_in = sum2[SUW-1:GAIN_SHIFT];
   end

   // stage 3: apply radius scale
   assign s3_in = SW'(r2_ff) * SW'(radius_scale);

   // stage 4: round and clamp
   always_comb begin
      s_round = (SW + 1)'(s3_ff) + (SW + 1)'(24'h800000);
      v       = s_round[SW:24];
      if (v > VW'(255)) begin
         code4_in = 8'd255;
         sat4_in  = 1'b1;
      end else begin
         code4_in = v[7:0];
         sat4_in  = 1'b0;
      end
   end

   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
         if (r4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && in_valid) begin
         hi1_ff  <= hi1_in;
         lo1_ff  <= lo1_in;
         ang1_ff <= ang1_in;
      end
      if (r2 && v1_ff) begin
         r2_ff   <= r2_in;
         ang2_ff <= ang1_ff;
      end
      if (r3 && v2_ff) begin
         s3_ff   <= s3_in;
         ang3_ff <= ang2_ff;
      end
      if (r4 && v3_ff) begin
         code4_ff <= code4_in;
         sat4_ff  <= sat4_in;
         ang4_ff  <= ang3_ff;
      end
   end

   assign out_valid        = v4_ff;
   assign angle_code       = ang4_ff;
   assign radius_code      = code4_ff;
   assign radius_saturated = sat4_ff;

   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && sat4_ff) |-> (code4_ff == 8'd255))
      else $error("saturated radius not clamped");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !out_ready) |=> (v4_ff && $stable(code4_ff) && $stable(ang4_ff)))
      else $error("stalled result changed");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("back end stalled while output drains");

endmodule

`default_nettype wire

>>> sv/cartesian_to_polar_byte.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_byte
// Cartesian-to-polar converter: one signed Q8.8 point in, angle and radius
// bytes out, through a fully pipelined CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_ (x, y coordinates), results leave on rsp_ (angle,
//   radius, saturation flag, column byte). Both channels use valid/ready.
//   Configuration registers are written on csr_; csr_ready is always high.
//   Write them only while no request is in flight.
// Pipeline: one input stage, a registered stage for each CORDIC rotation,
//   and four back-end stages for gain multiply, sum, scale multiply and
//   round/clamp.
// Throughput: one request per cycle while rsp_ready is high; every stage holds its own valid bit.
// Reset: synchronous; drops all in-flight requests, restores radius_scale to
//   32.0 and the column byte to 240.
// Stall: when rsp_ready is low the result holds; upstream stages keep filling
//   empty slots, and req_ready drops only when every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar_byte #(
   parameter int COORD_WIDTH   = c2p_pkg::C2P_COORD_WIDTH,
   parameter int CORDIC_STAGES = c2p_pkg::C2P_CORDIC_STAGES
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]          req_x_coord,
   input  wire logic signed [COORD_WIDTH-1:0]          req_y_coord,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [7:0]                                  rsp_angle_code,
   output logic [7:0]                                  rsp_radius_code,
   output logic                                        rsp_radius_saturated,
   output logic [7:0]                                  rsp_column_out,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [c2p_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [c2p_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import c2p_pkg::*;

   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + HEADROOM;

   logic [15:0] radius_scale_ff;
   logic [7:0]  x_column_ff;

   logic                         vld_s [CORDIC_STAGES+1];
   logic                         rdy_s [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0] x_s   [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0] y_s   [CORDIC_STAGES+1];
   logic [ANGLE_WIDTH-1:0]       z_s   [CORDIC_STAGES+1];
   logic                         nz_s  [CORDIC_STAGES+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_scale_ff <= RADIUS_SCALE_RESET;
         x_column_ff     <= X_COLUMN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_RADIUS_SCALE) begin
            radius_scale_ff <= csr_wdata[15:0];
         end
         if (csr_index == REG_X_COLUMN) begin
            x_column_ff <= csr_wdata[7:0];
         end
      end
   end

   c2p_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_coord   (req_x_coord),
      .y_coord   (req_y_coord),
      .out_valid (vld_s[0]),
      .out_ready (rdy_s[0]),
      .x_out     (x_s[0]),
      .y_out     (y_s[0]),
      .z_out     (z_s[0]),
      .nz_out    (nz_s[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      c2p_cordic_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_s[i]),
         .in_ready  (rdy_s[i]),
         .x_in_d    (x_s[i]),
         .y_in_d    (y_s[i]),
         .z_in_d    (z_s[i]),
         .nz_in_d   (nz_s[i]),
         .out_valid (vld_s[i+1]),
         .out_ready (rdy_s[i+1]),
         .x_out     (x_s[i+1]),
         .y_out     (y_s[i+1]),
         .z_out     (z_s[i+1]),
         .nz_out    (nz_s[i+1])
      );
   end

   c2p_radius #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_radius (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (vld_s[CORDIC_STAGES]),
      .in_ready         (rdy_s[CORDIC_STAGES]),
      .x_in_d           (x_s[CORDIC_STAGES]),
      .z_in_d           (z_s[CORDIC_STAGES]),
      .nz_in_d          (nz_s[CORDIC_STAGES]),
      .radius_scale     (radius_scale_ff),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .angle_code       (rsp_angle_code),
      .radius_code      (rsp_radius_code),
      .radius_saturated (rsp_radius_saturated)
   );

   assign rsp_column_out = x_column_ff;

   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline stalled while output drains");

   a_scale_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == REG_RADIUS_SCALE)
      |=> (radius_scale_ff == $past(csr_wdata[15:0])))
      else $error("radius scale write lost");

   a_column_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == REG_X_COLUMN)
      |=> (rsp_column_out == $past(csr_wdata[7:0])))
      else $error("column write lost");

endmodule

`default_nettype wire
